### hw/rtl/kbc_pkg.sv
// Shared constants, types and the scancode table for the keyboard text console.
`timescale 1ns / 1ps
`default_nettype none

package kbc_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int CUR_W       = $clog2(CELLS + 1);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int CELL_W      = 11;
    localparam int QUEUE_DEPTH = 2;
    localparam int RELEASE_BIT = 7;

    localparam logic [7:0] ATTR_RESET = 8'h0F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_PROMPT  = 8'h3E;
    localparam logic [7:0] SC_ENTER   = 8'h1C;
    localparam logic [7:0] SC_BACK    = 8'h0E;

    localparam logic [CUR_W-1:0] CURSOR_RESET = CUR_W'(2);
    localparam logic [COL_W-1:0] COL_RESET    = COL_W'(2);

    typedef enum logic [1:0] {
        OP_PUT,
        OP_BACK,
        OP_ENTER
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
    } item_t;

    function automatic logic [7:0] keymap(input logic [6:0] code);
        logic [7:0] ch;
        begin
            case (code)
                7'h1E: ch = "a";
                7'h30: ch = "b";
                7'h2E: ch = "c";
                7'h20: ch = "d";
                7'h12: ch = "e";
                7'h21: ch = "f";
                7'h22: ch = "g";
                7'h23: ch = "h";
                7'h17: ch = "i";
                7'h24: ch = "j";
                7'h25: ch = "k";
                7'h26: ch = "l";
                7'h32: ch = "m";
                7'h31: ch = "n";
                7'h18: ch = "o";
                7'h19: ch = "p";
                7'h10: ch = "q";
                7'h13: ch = "r";
                7'h1F: ch = "s";
                7'h14: ch = "t";
                7'h16: ch = "u";
                7'h2F: ch = "v";
                7'h11: ch = "w";
                7'h2D: ch = "x";
                7'h15: ch = "y";
                7'h2C: ch = "z";
                7'h39: ch = " ";
                7'h02: ch = "1";
                7'h03: ch = "2";
                7'h04: ch = "3";
                7'h05: ch = "4";
                7'h06: ch = "5";
                7'h07: ch = "6";
                7'h08: ch = "7";
                7'h09: ch = "8";
                7'h0A: ch = "9";
                7'h0B: ch = "0";
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/kbc_front.sv
// Front end: accepts scancodes, drops releases and unmapped keys, classifies the rest.
`timescale 1ns / 1ps
`default_nettype none

module kbc_front
    import kbc_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] scancode,
    input  logic       queue_full,
    input  logic       clearing,
    output logic       push,
    output item_t      push_item
);

    logic [7:0] ch;
    logic       keep;

    always_comb
    begin
        ch             = keymap(scancode[6:0]);
        push_item.ch   = ch;
        push_item.op   = OP_PUT;
        keep           = 1'b0;
        if (!scancode[RELEASE_BIT])
        begin
            if (scancode == SC_BACK)
            begin
                push_item.op = OP_BACK;
                keep         = 1'b1;
            end
            else if (scancode == SC_ENTER)
            begin
                push_item.op = OP_ENTER;
                keep         = 1'b1;
            end
            else
            begin
                keep = (ch != 8'h00);
            end
        end
    end

    assign in_ready = !queue_full && !clearing;
    assign push     = in_valid && in_ready && keep;

endmodule

`default_nettype wire

### hw/rtl/kbc_queue.sv
// Short queue of classified key operations between the front end and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module kbc_queue
    import kbc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    output logic  head_valid,
    output item_t head_item,
    input  logic  pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/kbc_back.sv
// Back end: cursor and screen sequencer, prompt-mark memory and output register.
`timescale 1ns / 1ps
`default_nettype none

module kbc_back
    import kbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  item_t             head_item,
    output logic              pop,
    output logic              clearing,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              kind,
    output logic [CELL_W-1:0] cell_res,
    output logic [7:0]        character,
    output logic [7:0]        attribute,
    output logic              last
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_BS_RD = 7'b0000100,
        S_ENT   = 7'b0001000,
        S_PUT_W = 7'b0010000,
        S_PUT_C = 7'b0100000,
        S_SPARE = 7'b1000000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CUR_W-1:0]  cursor_reg;
    logic [CUR_W-1:0]  cursor_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [CUR_W-1:0]  row_reg;
    logic [CUR_W-1:0]  row_next;
    logic [7:0]        ch_reg;
    logic [7:0]        ch_next;
    logic              second_reg;
    logic              second_next;
    logic [ADDR_W-1:0] clr_reg;
    logic [ADDR_W-1:0] clr_next;
    logic [7:0]        attr_reg;

    logic              mark_mem [CELLS];
    logic              rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_data;

    logic              out_valid_reg;
    logic              kind_reg;
    logic [CELL_W-1:0] cell_reg;
    logic [7:0]        char_reg;
    logic [7:0]        attr_out_reg;
    logic              last_reg;

    logic              emit_ok;
    logic              emit;
    logic              e_kind;
    logic [CUR_W-1:0]  e_cell;
    logic [7:0]        e_ch;
    logic [7:0]        e_attr;
    logic              e_last;

    logic [CUR_W-1:0]  cursor_minus;
    logic [CUR_W:0]    row_sum;
    logic              enter_full;
    logic [CUR_W-1:0]  enter_next;

    assign cursor_minus = cursor_reg - CUR_W'(1);
    assign row_sum      = {1'b0, row_reg} + (CUR_W + 1)'(COLUMNS);
    assign enter_full   = (row_sum >= (CUR_W + 1)'(CELLS));
    assign enter_next   = enter_full ? CUR_W'(CELLS) : row_sum[CUR_W-1:0];
    assign emit_ok      = !out_valid_reg || out_ready;
    assign clearing     = (state_reg == S_CLEAR);
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        ch_next     = ch_reg;
        second_next = second_reg;
        clr_next    = clr_reg;
        pop         = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = cursor_minus[ADDR_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = cursor_reg[ADDR_W-1:0];
        wr_data     = 1'b0;
        emit        = 1'b0;
        e_kind      = 1'b0;
        e_cell      = cursor_reg;
        e_ch        = 8'h00;
        e_attr      = 8'h00;
        e_last      = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = (clr_reg == ADDR_W'(1));
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    case (head_item.op)
                        OP_PUT:
                        begin
                            if (cursor_reg < CUR_W'(CELLS))
                            begin
                                ch_next     = head_item.ch;
                                second_next = 1'b0;
                                state_next  = S_PUT_W;
                            end
                        end
                        OP_BACK:
                        begin
                            if (cursor_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                state_next = S_BS_RD;
                            end
                        end
                        OP_ENTER:
                        begin
                            state_next = S_ENT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_BS_RD:
            begin
                if (rd_data_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (emit_ok)
                begin
                    emit        = 1'b1;
                    e_cell      = cursor_minus;
                    e_ch        = CH_SPACE;
                    e_attr      = attr_reg;
                    wr_en       = 1'b1;
                    wr_addr     = cursor_minus[ADDR_W-1:0];
                    cursor_next = cursor_minus;
                    if (col_reg == '0)
                    begin
                        col_next = COL_W'(COLUMNS - 1);
                        row_next = row_reg - CUR_W'(COLUMNS);
                    end
                    else
                    begin
                        col_next = col_reg - 1'b1;
                    end
                    second_next = 1'b0;
                    state_next  = S_PUT_C;
                end
            end
            S_ENT:
            begin
                if (emit_ok)
                begin
                    emit        = 1'b1;
                    e_kind      = 1'b1;
                    e_cell      = enter_next;
                    e_last      = enter_full;
                    cursor_next = enter_next;
                    col_next    = '0;
                    row_next    = enter_next;
                    if (enter_full)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next     = CH_DASH;
                        second_next = 1'b1;
                        state_next  = S_PUT_W;
                    end
                end
            end
            S_PUT_W:
            begin
                if (emit_ok)
                begin
                    emit        = 1'b1;
                    e_ch        = ch_reg;
                    e_attr      = attr_reg;
                    wr_en       = 1'b1;
                    wr_data     = (ch_reg == CH_PROMPT);
                    cursor_next = cursor_reg + CUR_W'(1);
                    if (col_reg == COL_W'(COLUMNS - 1))
                    begin
                        col_next = '0;
                        row_next = row_reg + CUR_W'(COLUMNS);
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    state_next = S_PUT_C;
                end
            end
            S_PUT_C:
            begin
                if (emit_ok)
                begin
                    emit   = 1'b1;
                    e_kind = 1'b1;
                    e_last = !second_reg || (cursor_reg >= CUR_W'(CELLS));
                    if (second_reg && (cursor_reg < CUR_W'(CELLS)))
                    begin
                        ch_next     = CH_PROMPT;
                        second_next = 1'b0;
                        state_next  = S_PUT_W;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            cursor_reg <= CURSOR_RESET;
            col_reg    <= COL_RESET;
            row_reg    <= '0;
            ch_reg     <= '0;
            second_reg <= 1'b0;
            clr_reg    <= '0;
            attr_reg   <= ATTR_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            ch_reg     <= ch_next;
            second_reg <= second_next;
            clr_reg    <= clr_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mark_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mark_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg     <= e_kind;
            cell_reg     <= CELL_W'(e_cell);
            char_reg     <= e_ch;
            attr_out_reg <= e_attr;
            last_reg     <= e_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign cell_res  = cell_reg;
    assign character = char_reg;
    assign attribute = attr_out_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

### hw/rtl/keyboard_text_console_top.sv
// Top level of the scancode-driven text console.
`timescale 1ns / 1ps
`default_nettype none

// Scancodes (set 1) enter through in_valid/in_ready and are classified at once: release and
// unmapped codes are dropped, the rest go into a two-entry queue, so a new scancode can be
// taken every cycle while the queue has room. The sequencer behind it produces at most one
// result a cycle and takes each operation from the queue in its idle state: a printing key
// gives a cell write and a cursor update, backspace the same (the prompt-mark memory is read
// as it is taken), enter a cursor update and then, if the screen has room, '-' and '>' with
// their cursor updates. Results sit in a single output register; the sequencer holds while a
// result waits, and the queue keeps taking scancodes until it fills.
// After reset every cell of the prompt-mark memory (COLUMNS*ROWS, 2000 at 80x25) is
// initialised while in_ready stays low; attribute writes are taken at any time.
module keyboard_text_console_top
    import kbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        scancode,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              kind,
    output logic [CELL_W-1:0] cell_res,
    output logic [7:0]        character,
    output logic [7:0]        attribute,
    output logic              last
);

    logic  push;
    item_t push_item;
    logic  queue_full;
    logic  head_valid;
    item_t head_item;
    logic  pop;
    logic  clearing;

    kbc_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .scancode   (scancode),
        .queue_full (queue_full),
        .clearing   (clearing),
        .push       (push),
        .push_item  (push_item)
    );

    kbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    kbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .clearing   (clearing),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .cell_res   (cell_res),
        .character  (character),
        .attribute  (attribute),
        .last       (last)
    );

endmodule

`default_nettype wire

### hw/rtl/kbc_checker.sv
// Port-level checks on the text console, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module kbc_checker
    import kbc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic              kind,
    input logic [CELL_W-1:0] cell_res,
    input logic [7:0]        character,
    input logic [7:0]        attribute,
    input logic              last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(cell_res)
            && $stable(character) && $stable(attribute) && $stable(last))
        else $error("result transaction changed while stalled");

    a_cursor_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> (character == 8'h00) && (attribute == 8'h00))
        else $error("cursor update carries character or attribute");

    a_cell_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cell_res <= CELL_W'(CELLS)))
        else $error("cell address beyond the screen");

    a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kind |-> !last)
        else $error("cell write marked as final result");

endmodule

bind keyboard_text_console_top kbc_checker u_checker (.*);

`default_nettype wire

### tb/tb_keyboard_text_console_top.sv
// Self-checking testbench for the scancode text console.
`timescale 1ns / 1ps

module tb_keyboard_text_console_top;
    import kbc_pkg::*;

    localparam logic       KIND_CELL   = 1'b0;
    localparam logic       KIND_CURSOR = 1'b1;
    localparam logic [7:0] SC_SPACE    = 8'h39;
    localparam int         HOLD_CYCLES = 400;
    localparam int         DRAIN_GAP   = 20;

    typedef struct packed {
        logic              kind;
        logic [CELL_W-1:0] pos;
        logic [7:0]        ch;
        logic [7:0]        attr;
        logic              last;
    } console_result_t;

    class console_scoreboard;
        byte unsigned    glyphs[CELLS];
        int unsigned     cursor;
        logic [7:0]      text_attr;
        byte unsigned    key_char[128];
        logic [7:0]      printable_codes[$];
        console_result_t expected_q[$];
        int              errors;

        function new();
            string top_row;
            string home_row;
            string low_row;
            string digits;
            top_row  = "qwertyuiop";
            home_row = "asdfghjkl";
            low_row  = "zxcvbnm";
            digits   = "1234567890";
            foreach (key_char[i])
                key_char[i] = 0;
            for (int i = 0; i < top_row.len(); i++)
                key_char[8'h10 + i] = top_row[i];
            for (int i = 0; i < home_row.len(); i++)
                key_char[8'h1E + i] = home_row[i];
            for (int i = 0; i < low_row.len(); i++)
                key_char[8'h2C + i] = low_row[i];
            for (int i = 0; i < digits.len(); i++)
                key_char[8'h02 + i] = digits[i];
            key_char[SC_SPACE] = CH_SPACE;
            foreach (key_char[i])
                if (key_char[i] != 0)
                    printable_codes.push_back(8'(i));
            foreach (glyphs[i])
                glyphs[i] = CH_SPACE;
            glyphs[0] = CH_DASH;
            glyphs[1] = CH_PROMPT;
            cursor    = 2;
            text_attr = ATTR_RESET;
            errors    = 0;
        endfunction

        function void push(logic kind, int unsigned pos, logic [7:0] ch, logic [7:0] attr);
            console_result_t r;
            r.kind = kind;
            r.pos  = CELL_W'(pos);
            r.ch   = ch;
            r.attr = attr;
            r.last = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void put_glyph(logic [7:0] ch);
            if (cursor >= CELLS)
                return;
            glyphs[cursor] = ch;
            push(KIND_CELL, cursor, ch, text_attr);
            cursor++;
            push(KIND_CURSOR, cursor, 8'h00, 8'h00);
        endfunction

        function void note_scancode(logic [7:0] code);
            int          before_n;
            int unsigned next_row;
            before_n = expected_q.size();
            if (code[RELEASE_BIT])
                return;
            if (code == SC_BACK)
            begin
                if (cursor == 0 || cursor > CELLS)
                    return;
                if (glyphs[cursor - 1] == CH_PROMPT)
                    return;
                cursor--;
                glyphs[cursor] = CH_SPACE;
                push(KIND_CELL, cursor, CH_SPACE, text_attr);
                push(KIND_CURSOR, cursor, 8'h00, 8'h00);
            end
            else if (code == SC_ENTER)
            begin
                next_row = (cursor / COLUMNS + 1) * COLUMNS;
                cursor   = (next_row > CELLS) ? CELLS : next_row;
                push(KIND_CURSOR, cursor, 8'h00, 8'h00);
                put_glyph(CH_DASH);
                put_glyph(CH_PROMPT);
            end
            else if (key_char[code[6:0]] != 0)
            begin
                put_glyph(key_char[code[6:0]]);
            end
            if (expected_q.size() > before_n)
                expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        function void check_result(console_result_t got);
            console_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result kind=%0d cell=%0d char=%h attr=%h last=%0d",
                             $realtime, got.kind, got.pos, got.ch, got.attr, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.pos !== want.pos || got.ch !== want.ch ||
                got.attr !== want.attr || got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: mismatch exp kind=%0d cell=%0d char=%h attr=%h last=%0d,",
                              " got kind=%0d cell=%0d char=%h attr=%h last=%0d"},
                             $realtime, want.kind, want.pos, want.ch, want.attr, want.last,
                             got.kind, got.pos, got.ch, got.attr, got.last);
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [7:0]        scancode  = 8'h00;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_data  = 8'h00;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              kind;
    logic [CELL_W-1:0] cell_res;
    logic [7:0]        character;
    logic [7:0]        attribute;
    logic              last;

    console_scoreboard sb;
    int                send_idle = 25;
    int                recv_idle = 54;
    logic              hold_rx   = 1'b0;

    keyboard_text_console_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .scancode  (scancode),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .cell_res  (cell_res),
        .character (character),
        .attribute (attribute),
        .last      (last)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_ready = hold_rx ? 1'b0 : ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        console_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.kind = kind;
            got.pos  = cell_res;
            got.ch   = character;
            got.attr = attribute;
            got.last = last;
            sb.check_result(got);
        end
    end

    task automatic send_scancode(input logic [7:0] code);
        while ($urandom_range(0, 99) < send_idle)
            @(negedge clk);
        in_valid = 1'b1;
        scancode = code;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_scancode(code);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_attribute(input logic [7:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.text_attr = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic settle();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_scancode(int enter_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < enter_pct)
            return SC_ENTER;
        if (roll < enter_pct + 15)
            return SC_BACK;
        if (roll < enter_pct + 25)
            return {1'b1, 7'($urandom)};
        if (roll < enter_pct + 33)
            return 8'($urandom);
        return sb.printable_codes[$urandom_range(0, sb.printable_codes.size() - 1)];
    endfunction

    task automatic run_random(input int count, input int enter_pct);
        repeat (count) send_scancode(pick_scancode(enter_pct));
    endtask

    initial
    begin
        logic [7:0] directed_codes[$];
        directed_codes = '{SC_BACK, 8'h00, 8'hFF, 8'h9E, 8'h1E, SC_SPACE, 8'h02, 8'h0B,
                           8'h10, 8'h2C, SC_BACK, SC_BACK, SC_BACK, SC_BACK, SC_BACK,
                           SC_BACK, SC_BACK, SC_ENTER, 8'h32, SC_ENTER, 8'h7F, 8'h80};
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_attribute(8'hFF);
        foreach (directed_codes[i])
            send_scancode(directed_codes[i]);

        settle();
        write_attribute(8'h00);
        run_random(90, 7);

        settle();
        send_idle = 54;
        recv_idle = 25;
        write_attribute(8'($urandom_range(1, 254)));
        run_random(90, 7);

        settle();
        send_idle = 0;
        recv_idle = 0;
        write_attribute(8'($urandom));
        fork
            begin
                hold_rx = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_rx = 1'b0;
            end
        join_none
        run_random(70, 25);

        settle();
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_keyboard_text_console_top: done, clean");
        else
            $display("tb_keyboard_text_console_top: done, errors");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("tb_keyboard_text_console_top: done, errors");
        $finish;
    end

endmodule

### sim.f
hw/rtl/kbc_pkg.sv
hw/rtl/kbc_front.sv
hw/rtl/kbc_queue.sv
hw/rtl/kbc_back.sv
hw/rtl/keyboard_text_console_top.sv
hw/rtl/kbc_checker.sv
tb/tb_keyboard_text_console_top.sv
